// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the attribute-value group parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define AVP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset
`define AVP_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: src/avp_gp_pkg.sv
// ----------------------------------------------------------------------------
// avp_gp_pkg
// Types and constants shared by the group parser modules.
// ----------------------------------------------------------------------------
package avp_gp_pkg;

    // Result status codes
    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_END     = 2'd2;

    // Record header layout
    localparam int MIN_PLAIN   = 8;
    localparam int MIN_VENDOR  = 12;
    localparam int VENDOR_BIT  = 7;

    // Event queue between parser and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // One parser event; also_end appends an end-of-group item after a record
    typedef struct packed {
        logic [1:0]  status;
        logic        also_end;
        logic [31:0] avp_code;
        logic [31:0] vendor_val;
        logic [23:0] payload_length;
        logic [23:0] payload_offset;
    } avp_event_t;

endpackage

// File: src/avp_gp_front.sv
// ----------------------------------------------------------------------------
// avp_gp_front
// Byte parser: walks record headers, checks lengths, skips padded payload
// and classifies each accepted byte into at most one queue event.
// ----------------------------------------------------------------------------
module avp_gp_front #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   take,
    input  logic [7:0]             data_byte,
    input  logic                   start_of_group,
    input  logic [23:0]            group_length,
    output logic                   ev_valid,
    output avp_gp_pkg::avp_event_t ev
);
    import avp_gp_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;

    logic [1:0]             phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    logic [LENGTH_BITS-1:0] gsize_reg, gsize_next;
    logic [3:0]             hidx_reg, hidx_next;
    logic [24:0]            skip_reg, skip_next;
    logic [31:0]            code_reg, code_next;
    logic [7:0]             flag_reg, flag_next;
    logic [23:0]            rlen_reg, rlen_next;
    logic [31:0]            vend_reg, vend_next;

    logic [1:0]             cur_phase;
    logic [LENGTH_BITS-1:0] cur_pos;
    logic [LENGTH_BITS-1:0] cur_gsize;
    logic [3:0]             cur_hidx;
    logic [24:0]            cur_skip;
    logic [LENGTH_BITS:0]   next_pos;
    logic                   at_end;
    logic                   boundary;
    logic                   has_vendor;
    logic                   too_short;
    logic                   overrun;
    logic [23:0]            full_len;
    logic [24:0]            padded;
    logic [LENGTH_BITS-1:0] rec_start;
    logic                   zero_group;

    // Per-byte parse step
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        gsize_next = gsize_reg;
        hidx_next  = hidx_reg;
        skip_next  = skip_reg;
        code_next  = code_reg;
        flag_next  = flag_reg;
        rlen_next  = rlen_reg;
        vend_next  = vend_reg;
        ev_valid   = 1'b0;
        ev         = '0;
        cur_phase  = phase_reg;
        cur_pos    = pos_reg;
        cur_gsize  = gsize_reg;
        cur_hidx   = hidx_reg;
        cur_skip   = skip_reg;
        boundary   = 1'b0;
        zero_group = 1'b0;
        has_vendor = flag_reg[VENDOR_BIT];
        full_len   = {rlen_reg[15:0], data_byte};
        padded     = '0;
        too_short  = 1'b0;
        overrun    = 1'b0;
        rec_start  = pos_reg - LENGTH_BITS'(7);
        next_pos   = {1'b0, pos_reg} + (LENGTH_BITS+1)'(1);
        at_end     = 1'b0;

        if (take) begin
            // start byte restarts the group
            if (start_of_group) begin
                cur_gsize  = group_length[LENGTH_BITS-1:0];
                gsize_next = cur_gsize;
                cur_pos    = '0;
                cur_hidx   = '0;
                cur_skip   = '0;
                pos_next   = '0;
                hidx_next  = '0;
                skip_next  = '0;
                if (cur_gsize == '0) begin
                    zero_group = 1'b1;
                    ev_valid   = 1'b1;
                    ev.status  = ST_END;
                    phase_next = PH_IDLE;
                    cur_phase  = PH_IDLE;
                end else begin
                    cur_phase  = PH_HEADER;
                    phase_next = PH_HEADER;
                end
            end

            if (!zero_group && cur_phase != PH_IDLE) begin
                next_pos  = {1'b0, cur_pos} + (LENGTH_BITS+1)'(1);
                pos_next  = next_pos[LENGTH_BITS-1:0];
                at_end    = next_pos >= {1'b0, cur_gsize};
                rec_start = cur_pos - LENGTH_BITS'(7);

                if (cur_phase == PH_HEADER) begin
                    // header byte capture
                    if (cur_hidx < 4'd4) begin
                        code_next = {code_reg[23:0], data_byte};
                    end else if (cur_hidx == 4'd4) begin
                        flag_next = data_byte;
                    end else if (cur_hidx < 4'd8) begin
                        rlen_next = full_len;
                    end else begin
                        vend_next = {vend_reg[23:0], data_byte};
                    end

                    if (cur_hidx < 4'd7) begin
                        if (at_end) begin
                            ev_valid   = 1'b1;
                            ev.status  = ST_INVALID;
                            phase_next = PH_IDLE;
                        end else begin
                            hidx_next = cur_hidx + 4'd1;
                        end
                    end else if (cur_hidx == 4'd7) begin
                        // length check on the last length byte
                        padded    = ({1'b0, full_len} + 25'd3) & ~25'd3;
                        too_short = has_vendor ? (full_len < 24'(MIN_VENDOR))
                                               : (full_len < 24'(MIN_PLAIN));
                        overrun   = (26'(rec_start) + 26'(padded)) > 26'(cur_gsize);
                        if (too_short || overrun) begin
                            ev_valid   = 1'b1;
                            ev.status  = ST_INVALID;
                            phase_next = PH_IDLE;
                        end else if (!has_vendor) begin
                            ev_valid          = 1'b1;
                            ev.status         = ST_FOUND;
                            ev.avp_code       = code_reg;
                            ev.payload_length = full_len - 24'(MIN_PLAIN);
                            ev.payload_offset = 24'(next_pos);
                            cur_skip          = padded - 25'(MIN_PLAIN);
                            skip_next         = cur_skip;
                            boundary          = 1'b1;
                        end else begin
                            hidx_next = 4'd8;
                        end
                    end else if (cur_hidx < 4'd11) begin
                        hidx_next = cur_hidx + 4'd1;
                    end else if (cur_hidx == 4'd11) begin
                        // vendor record complete
                        padded            = ({1'b0, rlen_reg} + 25'd3) & ~25'd3;
                        ev_valid          = 1'b1;
                        ev.status         = ST_FOUND;
                        ev.avp_code       = code_reg;
                        ev.vendor_val     = {vend_reg[23:0], data_byte};
                        ev.payload_length = rlen_reg - 24'(MIN_VENDOR);
                        ev.payload_offset = 24'(next_pos);
                        cur_skip          = padded - 25'(MIN_VENDOR);
                        skip_next         = cur_skip;
                        boundary          = 1'b1;
                    end
                end else begin
                    // payload skip
                    if (cur_skip != '0) begin
                        cur_skip = cur_skip - 25'd1;
                    end
                    skip_next = cur_skip;
                    boundary  = 1'b1;
                end

                // record boundary: next record, skip, or end of group
                if (boundary) begin
                    if (cur_skip == '0) begin
                        if (at_end) begin
                            if (ev_valid) begin
                                ev.also_end = 1'b1;
                            end else begin
                                ev_valid  = 1'b1;
                                ev.status = ST_END;
                            end
                            phase_next = PH_IDLE;
                        end else begin
                            hidx_next  = '0;
                            skip_next  = '0;
                            phase_next = PH_HEADER;
                        end
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            gsize_reg <= '0;
            hidx_reg  <= '0;
            skip_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            gsize_reg <= gsize_next;
            hidx_reg  <= hidx_next;
            skip_reg  <= skip_next;
        end
    end

    // Header payload registers
    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        flag_reg <= flag_next;
        rlen_reg <= rlen_next;
        vend_reg <= vend_next;
    end

endmodule

// File: src/avp_gp_queue.sv
// ----------------------------------------------------------------------------
// avp_gp_queue
// Short event queue between the byte parser and the output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module avp_gp_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  avp_gp_pkg::avp_event_t push_ev,
    input  logic                   pop,
    output avp_gp_pkg::avp_event_t head_ev,
    output logic                   empty,
    output logic                   full
);
    import avp_gp_pkg::*;

    avp_event_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign head_ev = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_BITS'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Event storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_ev;
        end
    end

    `AVP_NEVER(a_no_overflow, aclk, aresetn, push && full, "push into full queue")
    `AVP_NEVER(a_no_underflow, aclk, aresetn, pop && empty, "pop from empty queue")
    `AVP_ASSERT(a_count_bound, aclk, aresetn, count_reg <= QCNT_BITS'(QUEUE_DEPTH), "count beyond depth")

endmodule

// File: src/avp_gp_back.sv
// ----------------------------------------------------------------------------
// avp_gp_back
// Output stage: turns queue events into result items in an output
// register, adding the end-of-group item that follows a final record.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module avp_gp_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  avp_gp_pkg::avp_event_t head_ev,
    input  logic                   q_empty,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [111:0]           m_tdata,
    output logic [1:0]             m_tuser,
    output logic                   m_tlast
);
    import avp_gp_pkg::*;

    logic         valid_reg, valid_next;
    logic         pend_end_reg, pend_end_next;
    logic [1:0]   status_reg, status_next;
    logic [111:0] data_reg, data_next;
    logic         last_reg, last_next;
    logic         load;

    assign load  = !valid_reg || m_tready;
    assign q_pop = load && !pend_end_reg && !q_empty;

    // Next output item
    always_comb begin
        valid_next    = valid_reg;
        pend_end_next = pend_end_reg;
        status_next   = status_reg;
        data_next     = data_reg;
        last_next     = last_reg;
        if (load) begin
            if (pend_end_reg) begin
                valid_next    = 1'b1;
                pend_end_next = 1'b0;
                status_next   = ST_END;
                data_next     = '0;
                last_next     = 1'b1;
            end else if (!q_empty) begin
                valid_next    = 1'b1;
                pend_end_next = head_ev.also_end;
                status_next   = head_ev.status;
                data_next     = {head_ev.payload_offset, head_ev.payload_length,
                                 head_ev.vendor_val, head_ev.avp_code};
                last_next     = !head_ev.also_end;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            pend_end_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            pend_end_reg <= pend_end_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

    `AVP_ASSERT(a_pend_needs_item, aclk, aresetn, pend_end_reg |-> valid_reg, "pending end without item")
    `AVP_ASSERT(a_pend_not_last, aclk, aresetn, pend_end_reg |-> !last_reg, "record before end marked last")
    `AVP_ASSERT(a_end_follows, aclk, aresetn, (pend_end_reg && m_tready) |=> (valid_reg && last_reg && status_reg == ST_END), "end item missing after record")

endmodule

// File: src/avp_group_parser.sv
// ----------------------------------------------------------------------------
// avp_group_parser
// Streaming parser for attribute-value records in a byte-serial group.
// ----------------------------------------------------------------------------
// The block takes one group byte per cycle on the s_ side while s_tready is
// high. On the m_ side it reports one item per record found, per invalid
// record (bad length, or header cut short by the end of group), and per end
// of group reached without an invalid record. Each byte is parsed in the
// cycle it is accepted; its result is written into the event queue and from
// there into the output register, where it can be taken. A byte that ends a
// record exactly at the end of the group produces two items (record, then
// end of group), which the output register sends one after the other; a
// four-entry event queue between the parser and the output stage absorbs
// this and any back-pressure, and s_tready drops only when that queue is full.
// LENGTH_BITS sets the width of the internal byte counter and group size;
// only the low LENGTH_BITS bits of group_length are used.
module avp_group_parser #(
    parameter int LENGTH_BITS = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [7:0] data_byte, [31:8] group_length
    input  logic         s_tuser,   // [0] start_of_group
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // [31:0] avp_code, [63:32] vendor_val,
                                    // [87:64] payload_length,
                                    // [111:88] payload_offset
    output logic [1:0]   m_tuser,   // [1:0] status
    output logic         m_tlast    // is_last
);
    import avp_gp_pkg::*;

    logic       take;
    logic       ev_valid;
    avp_event_t ev;
    avp_event_t head_ev;
    logic       q_empty;
    logic       q_full;
    logic       q_pop;

    assign s_tready = !q_full;
    assign take     = s_tvalid && s_tready;

    // Byte parser
    avp_gp_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .take           (take),
        .data_byte      (s_tdata[7:0]),
        .start_of_group (s_tuser),
        .group_length   (s_tdata[31:8]),
        .ev_valid       (ev_valid),
        .ev             (ev)
    );

    // Event queue
    avp_gp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (ev_valid),
        .push_ev (ev),
        .pop     (q_pop),
        .head_ev (head_ev),
        .empty   (q_empty),
        .full    (q_full)
    );

    // Output stage
    avp_gp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_ev  (head_ev),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
